[design/segment_intersect_2d_macros.svh]
// Assertion macros used by the segment intersection RTL.
`ifndef SEGMENT_INTERSECT_2D_MACROS_SVH
`define SEGMENT_INTERSECT_2D_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SI2D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define SI2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/si2d_pkg.sv]
// Types and constants of the 2D segment intersection block.
`default_nettype none

package si2d_pkg;

  localparam int unsigned FRAC_W = 16;             // fraction bits of a Q16.16 point
  localparam int unsigned QUO_W  = 2 * FRAC_W;     // quotient bits, one per divider stage
  localparam int unsigned DEN_W  = 33;             // magnitude of the cross product
  localparam int unsigned NUM_W  = DEN_W + FRAC_W; // offset numerator magnitude

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_POINT   = 2'd1;
  localparam logic [1:0] KIND_OVERLAP = 2'd2;

  typedef struct packed {
    logic signed [15:0] a_start_x;
    logic signed [15:0] a_start_y;
    logic signed [15:0] a_end_x;
    logic signed [15:0] a_end_y;
    logic signed [15:0] b_start_x;
    logic signed [15:0] b_start_y;
    logic signed [15:0] b_end_x;
    logic signed [15:0] b_end_y;
  } si2d_in_t;

  typedef struct packed {
    logic [1:0]         meet_kind;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
  } si2d_out_t;

endpackage

`default_nettype wire

[design/si2d_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module si2d_div import si2d_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  // Partial remainder and divisor of every stage but the last.
  logic [DEN_W-1:0] rem_q [QUO_W-1];
  logic [DEN_W-1:0] den_q [QUO_W-1];
  // Low dividend bits shift out at the top while quotient bits shift in below.
  logic [QUO_W-1:0] sh_q  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] sh_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      // Quotient stays below 2^32, so the top bits already sit below the divisor.
      assign rem_in = num_i[NUM_W-1:FRAC_W];
      assign den_in = den_i;
      assign sh_in  = {num_i[FRAC_W-1:0], {FRAC_W{1'b0}}};
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign sh_in  = sh_q[k-1];
    end

    assign trial = {rem_in, sh_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sh_q[k] <= {sh_in[QUO_W-2:0], take};
      end
    end

    if (k < QUO_W - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = sh_q[QUO_W-1];

endmodule

`default_nettype wire

[design/segment_intersect_2d.sv]
// Top level of the 2D segment-segment intersection pipeline.
// Takes one pair of integer segments per clock and returns how they meet with
// the meeting points in Q16.16. The pipeline is 38 register stages deep:
// five stages form differences, cross products, the case decision and the
// offset numerators, then 32 stages of a restoring divider (one quotient bit
// per stage, four dividers side by side) produce the fractions, and a last
// stage adds the start point and drives the output register. The sustained
// rate is one pair per clock while the output is not stalled. Stall on the
// output freezes the whole pipeline; no state is kept between pairs and no
// sweep follows reset.
`default_nettype none
`include "segment_intersect_2d_macros.svh"

module segment_intersect_2d import si2d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  si2d_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output si2d_out_t out_data_o
);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               negx;
    logic               negy;
  } side_t;

  function automatic logic within16(input logic signed [15:0] p,
                                    input logic signed [15:0] s0,
                                    input logic signed [15:0] s1);
    return (s0 <= p && p <= s1) || (s0 >= p && p >= s1);
  endfunction

  function automatic logic [31:0] q_point(input logic signed [15:0] start,
                                          input logic neg,
                                          input logic [QUO_W-1:0] quo);
    logic [33:0] base;
    logic [33:0] frac;
    logic [33:0] sum;
    base = {{2{start[15]}}, start, {FRAC_W{1'b0}}};
    frac = neg ? (34'd0 - {2'b0, quo}) : {2'b0, quo};
    sum  = base + frac;
    return sum[31:0];
  endfunction

  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------- stage 1: differences and point-in-segment tests
  logic signed [16:0] ax0_e, ay0_e, ax1_e, ay1_e, bx0_e, by0_e, bx1_e, by1_e;
  logic               a_in_b, b_in_a;

  assign ax0_e = {in_data_i.a_start_x[15], in_data_i.a_start_x};
  assign ay0_e = {in_data_i.a_start_y[15], in_data_i.a_start_y};
  assign ax1_e = {in_data_i.a_end_x[15], in_data_i.a_end_x};
  assign ay1_e = {in_data_i.a_end_y[15], in_data_i.a_end_y};
  assign bx0_e = {in_data_i.b_start_x[15], in_data_i.b_start_x};
  assign by0_e = {in_data_i.b_start_y[15], in_data_i.b_start_y};
  assign bx1_e = {in_data_i.b_end_x[15], in_data_i.b_end_x};
  assign by1_e = {in_data_i.b_end_y[15], in_data_i.b_end_y};

  // Measure along x unless the segment is vertical.
  assign a_in_b = (in_data_i.b_start_x != in_data_i.b_end_x)
      ? within16(in_data_i.a_start_x, in_data_i.b_start_x, in_data_i.b_end_x)
      : within16(in_data_i.a_start_y, in_data_i.b_start_y, in_data_i.b_end_y);
  assign b_in_a = (in_data_i.a_start_x != in_data_i.a_end_x)
      ? within16(in_data_i.b_start_x, in_data_i.a_start_x, in_data_i.a_end_x)
      : within16(in_data_i.b_start_y, in_data_i.a_start_y, in_data_i.a_end_y);

  logic               s1_vld_q;
  logic signed [16:0] s1_ux_q, s1_uy_q, s1_vx_q, s1_vy_q, s1_wx_q, s1_wy_q;
  logic signed [16:0] s1_n1x_q, s1_n1y_q;
  logic signed [15:0] s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  logic               s1_ainb_q, s1_bina_q;

  // ---------------- stage 2: cross-product terms
  logic               s2_vld_q;
  logic signed [33:0] s2_p0_q, s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q, s2_p5_q;
  logic signed [16:0] s2_ux_q, s2_uy_q, s2_vx_q, s2_vy_q, s2_wx_q, s2_wy_q;
  logic signed [16:0] s2_n1x_q, s2_n1y_q;
  logic signed [15:0] s2_ax_q, s2_ay_q, s2_bx_q, s2_by_q;
  logic               s2_ainb_q, s2_bina_q;

  // ---------------- stage 3: cross products and collinear parameters
  logic signed [34:0] d_d, puw_d, pvw_d;
  logic signed [17:0] c_n0, c_n1, c_dn, c_lo, c_hi;

  assign d_d   = {s2_p0_q[33], s2_p0_q} - {s2_p1_q[33], s2_p1_q};
  assign puw_d = {s2_p2_q[33], s2_p2_q} - {s2_p3_q[33], s2_p3_q};
  assign pvw_d = {s2_p4_q[33], s2_p4_q} - {s2_p5_q[33], s2_p5_q};

  always_comb begin
    if (s2_vx_q != '0) begin
      c_n0 = {s2_wx_q[16], s2_wx_q};
      c_n1 = {s2_n1x_q[16], s2_n1x_q};
      c_dn = {s2_vx_q[16], s2_vx_q};
    end else begin
      c_n0 = {s2_wy_q[16], s2_wy_q};
      c_n1 = {s2_n1y_q[16], s2_n1y_q};
      c_dn = {s2_vy_q[16], s2_vy_q};
    end
    // Flip to a positive run along B.
    if (c_dn[17]) begin
      c_n0 = -c_n0;
      c_n1 = -c_n1;
      c_dn = -c_dn;
    end
    c_lo = (c_n0 > c_n1) ? c_n1 : c_n0;
    c_hi = (c_n0 > c_n1) ? c_n0 : c_n1;
  end

  logic               s3_vld_q;
  logic signed [34:0] s3_d_q, s3_puw_q, s3_pvw_q;
  logic signed [17:0] s3_cn0_q, s3_cn1_q, s3_cden_q;
  logic               s3_apt_q, s3_bpt_q, s3_peq_q;
  logic signed [16:0] s3_ux_q, s3_uy_q, s3_vx_q, s3_vy_q;
  logic signed [15:0] s3_ax_q, s3_ay_q, s3_bx_q, s3_by_q;
  logic               s3_ainb_q, s3_bina_q;

  // ---------------- stage 4: case decision
  logic signed [34:0] dabs, sn, tn;
  logic               hit;
  logic signed [17:0] lo_c, hi_c;
  logic [1:0]         kind_d;
  logic signed [15:0] sx_d, sy_d;
  logic [DEN_W-1:0]   m0_d, m1_d, den_d;
  logic signed [16:0] fx_d, fy_d;

  assign dabs = s3_d_q[34] ? -s3_d_q : s3_d_q;
  assign sn   = s3_d_q[34] ? -s3_pvw_q : s3_pvw_q;
  assign tn   = s3_d_q[34] ? -s3_puw_q : s3_puw_q;
  assign hit  = !sn[34] && (sn <= dabs) && !tn[34] && (tn <= dabs);
  assign lo_c = s3_cn0_q[17] ? '0 : s3_cn0_q;
  assign hi_c = (s3_cn1_q > s3_cden_q) ? s3_cden_q : s3_cn1_q;

  always_comb begin
    kind_d = KIND_NONE;
    sx_d   = s3_ax_q;
    sy_d   = s3_ay_q;
    m0_d   = '0;
    m1_d   = '0;
    fx_d   = '0;
    fy_d   = '0;
    den_d  = DEN_W'(1);
    if (s3_d_q != '0) begin
      if (hit) begin
        kind_d = KIND_POINT;
        m0_d   = sn[DEN_W-1:0];
        fx_d   = s3_ux_q;
        fy_d   = s3_uy_q;
        den_d  = dabs[DEN_W-1:0];
      end
    end else if (s3_puw_q != '0 || s3_pvw_q != '0) begin
      kind_d = KIND_NONE; // parallel, apart
    end else if (s3_apt_q || s3_bpt_q) begin
      if (s3_apt_q && s3_bpt_q) begin
        kind_d = s3_peq_q ? KIND_POINT : KIND_NONE;
      end else if (s3_apt_q) begin
        kind_d = s3_ainb_q ? KIND_POINT : KIND_NONE;
      end else begin
        kind_d = s3_bina_q ? KIND_POINT : KIND_NONE;
        sx_d   = s3_bx_q;
        sy_d   = s3_by_q;
      end
    end else begin
      sx_d = s3_bx_q;
      sy_d = s3_by_q;
      if (!(s3_cn0_q > s3_cden_q || s3_cn1_q[17])) begin
        kind_d = (lo_c == hi_c) ? KIND_POINT : KIND_OVERLAP;
        m0_d   = {15'd0, lo_c};
        m1_d   = {15'd0, hi_c};
        fx_d   = s3_vx_q;
        fy_d   = s3_vy_q;
        den_d  = {15'd0, s3_cden_q};
      end
    end
  end

  logic               s4_vld_q;
  logic [1:0]         s4_kind_q;
  logic signed [15:0] s4_sx_q, s4_sy_q;
  logic [DEN_W-1:0]   s4_m0_q, s4_m1_q, s4_den_q;
  logic signed [16:0] s4_fx_q, s4_fy_q;

  // ---------------- stage 5: offset numerators
  logic signed [16:0] nfx, nfy;
  logic [15:0]        afx, afy;

  assign nfx = -s4_fx_q;
  assign nfy = -s4_fy_q;
  assign afx = s4_fx_q[16] ? nfx[15:0] : s4_fx_q[15:0];
  assign afy = s4_fy_q[16] ? nfy[15:0] : s4_fy_q[15:0];

  logic             s5_vld_q;
  logic [NUM_W-1:0] s5_n0x_q, s5_n0y_q, s5_n1x_q, s5_n1y_q;
  logic [DEN_W-1:0] s5_den_q;
  side_t            s5_side_q;

  // ---------------- divider stages
  logic [QUO_W-1:0] q0x, q0y, q1x, q1y;
  logic [QUO_W-1:0] div_vld_q;
  side_t            side_q [QUO_W];

  si2d_div u_div_fx (.clk_i(clk_i), .en_i(adv), .num_i(s5_n0x_q), .den_i(s5_den_q), .quo_o(q0x));
  si2d_div u_div_fy (.clk_i(clk_i), .en_i(adv), .num_i(s5_n0y_q), .den_i(s5_den_q), .quo_o(q0y));
  si2d_div u_div_sx (.clk_i(clk_i), .en_i(adv), .num_i(s5_n1x_q), .den_i(s5_den_q), .quo_o(q1x));
  si2d_div u_div_sy (.clk_i(clk_i), .en_i(adv), .num_i(s5_n1y_q), .den_i(s5_den_q), .quo_o(q1y));

  // ---------------- output stage
  side_t     last;
  si2d_out_t out_d;

  assign last = side_q[QUO_W-1];

  always_comb begin
    out_d.meet_kind = last.kind;
    out_d.first_x   = q_point(last.sx, last.negx, q0x);
    out_d.first_y   = q_point(last.sy, last.negy, q0y);
    out_d.second_x  = q_point(last.sx, last.negx, q1x);
    out_d.second_y  = q_point(last.sy, last.negy, q1y);
    if (last.kind == KIND_NONE) begin
      out_d.first_x = '0;
      out_d.first_y = '0;
    end
    if (last.kind != KIND_OVERLAP) begin
      out_d.second_x = '0;
      out_d.second_y = '0;
    end
  end

  logic      out_vld_q;
  si2d_out_t out_data_q;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  // Valid bits travel with the beats; hold everything while the output is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      div_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      div_vld_q <= {div_vld_q[QUO_W-2:0], s5_vld_q};
      out_vld_q <= div_vld_q[QUO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ux_q   <= ax1_e - ax0_e;
      s1_uy_q   <= ay1_e - ay0_e;
      s1_vx_q   <= bx1_e - bx0_e;
      s1_vy_q   <= by1_e - by0_e;
      s1_wx_q   <= ax0_e - bx0_e;
      s1_wy_q   <= ay0_e - by0_e;
      s1_n1x_q  <= ax1_e - bx0_e;
      s1_n1y_q  <= ay1_e - by0_e;
      s1_ax_q   <= in_data_i.a_start_x;
      s1_ay_q   <= in_data_i.a_start_y;
      s1_bx_q   <= in_data_i.b_start_x;
      s1_by_q   <= in_data_i.b_start_y;
      s1_ainb_q <= a_in_b;
      s1_bina_q <= b_in_a;

      s2_p0_q   <= s1_ux_q * s1_vy_q;
      s2_p1_q   <= s1_uy_q * s1_vx_q;
      s2_p2_q   <= s1_ux_q * s1_wy_q;
      s2_p3_q   <= s1_uy_q * s1_wx_q;
      s2_p4_q   <= s1_vx_q * s1_wy_q;
      s2_p5_q   <= s1_vy_q * s1_wx_q;
      s2_ux_q   <= s1_ux_q;
      s2_uy_q   <= s1_uy_q;
      s2_vx_q   <= s1_vx_q;
      s2_vy_q   <= s1_vy_q;
      s2_wx_q   <= s1_wx_q;
      s2_wy_q   <= s1_wy_q;
      s2_n1x_q  <= s1_n1x_q;
      s2_n1y_q  <= s1_n1y_q;
      s2_ax_q   <= s1_ax_q;
      s2_ay_q   <= s1_ay_q;
      s2_bx_q   <= s1_bx_q;
      s2_by_q   <= s1_by_q;
      s2_ainb_q <= s1_ainb_q;
      s2_bina_q <= s1_bina_q;

      s3_d_q    <= d_d;
      s3_puw_q  <= puw_d;
      s3_pvw_q  <= pvw_d;
      s3_cn0_q  <= c_lo;
      s3_cn1_q  <= c_hi;
      s3_cden_q <= c_dn;
      s3_apt_q  <= (s2_ux_q == '0) && (s2_uy_q == '0);
      s3_bpt_q  <= (s2_vx_q == '0) && (s2_vy_q == '0);
      s3_peq_q  <= (s2_wx_q == '0) && (s2_wy_q == '0);
      s3_ux_q   <= s2_ux_q;
      s3_uy_q   <= s2_uy_q;
      s3_vx_q   <= s2_vx_q;
      s3_vy_q   <= s2_vy_q;
      s3_ax_q   <= s2_ax_q;
      s3_ay_q   <= s2_ay_q;
      s3_bx_q   <= s2_bx_q;
      s3_by_q   <= s2_by_q;
      s3_ainb_q <= s2_ainb_q;
      s3_bina_q <= s2_bina_q;

      s4_kind_q <= kind_d;
      s4_sx_q   <= sx_d;
      s4_sy_q   <= sy_d;
      s4_m0_q   <= m0_d;
      s4_m1_q   <= m1_d;
      s4_den_q  <= den_d;
      s4_fx_q   <= fx_d;
      s4_fy_q   <= fy_d;

      s5_n0x_q       <= s4_m0_q * afx;
      s5_n0y_q       <= s4_m0_q * afy;
      s5_n1x_q       <= s4_m1_q * afx;
      s5_n1y_q       <= s4_m1_q * afy;
      s5_den_q       <= s4_den_q;
      s5_side_q.kind <= s4_kind_q;
      s5_side_q.sx   <= s4_sx_q;
      s5_side_q.sy   <= s4_sy_q;
      s5_side_q.negx <= s4_fx_q[16];
      s5_side_q.negy <= s4_fy_q[16];

      side_q[0] <= s5_side_q;
      for (int k = 1; k < QUO_W; k++) begin
        side_q[k] <= side_q[k-1];
      end

      out_data_q <= out_d;
    end
  end

  `SI2D_ASSERT_IMPL(a_none_zero, clk_i, rst_ni, out_valid_o && out_data_o.meet_kind == KIND_NONE, out_data_o.first_x == '0 && out_data_o.first_y == '0, "disjoint result carries a point")
  `SI2D_ASSERT_IMPL(a_second_zero, clk_i, rst_ni, out_valid_o && out_data_o.meet_kind != KIND_OVERLAP, out_data_o.second_x == '0 && out_data_o.second_y == '0, "overlap end set without overlap")
  `SI2D_ASSERT_IMPL(a_stall_src, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input held without output back-pressure")
  `SI2D_ASSERT_NEXT(a_freeze, clk_i, rst_ni, in_stall_o, $stable(div_vld_q), "divider valids moved during a hold")

endmodule

`default_nettype wire
